// ----- sv/ctb_pkg.sv -----
// Shared widths, constants and reset values for the cycle counter timebase.
// No dependencies; every other file refers to it by scoped names.
package ctb_pkg;

	localparam int RAW_WIDTH_DEFAULT = 32;

	localparam int FREQ_W  = 12;
	localparam int COUNT_W = 32;
	localparam int TOTAL_W = 64;
	localparam int SEC_W   = 45;
	localparam int SUB_W   = 10;
	localparam int STEP_W  = $clog2(SEC_W + 1);

	localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(168);

	localparam logic [COUNT_W-1:0] CYC_PER_S_PER_MHZ  = COUNT_W'(1000000);
	localparam logic [COUNT_W-1:0] CYC_PER_MS_PER_MHZ = COUNT_W'(1000);

endpackage

// ----- sv/ctb_sample_if.sv -----
// Input channel of the timebase: one counter sample and a reference sample per beat.
// Depends on ctb_pkg for field widths.
interface ctb_sample_if;
	logic                        valid;
	logic                        ready;
	logic [ctb_pkg::COUNT_W-1:0] cycle_count;
	logic [ctb_pkg::COUNT_W-1:0] reference_count;

	modport source (output valid, cycle_count, reference_count, input ready);
	modport sink   (input valid, cycle_count, reference_count, output ready);
endinterface

// ----- sv/ctb_result_if.sv -----
// Output channel of the timebase: extended count and its time split per beat.
// Depends on ctb_pkg for field widths.
interface ctb_result_if;
	logic                        valid;
	logic                        ready;
	logic [ctb_pkg::COUNT_W-1:0] elapsed_cycles;
	logic [ctb_pkg::TOTAL_W-1:0] total_cycles;
	logic [ctb_pkg::SEC_W-1:0]   seconds;
	logic [ctb_pkg::SUB_W-1:0]   milliseconds;
	logic [ctb_pkg::SUB_W-1:0]   microseconds;

	modport source (output valid, elapsed_cycles, total_cycles, seconds, milliseconds,
		microseconds, input ready);
	modport sink   (input valid, elapsed_cycles, total_cycles, seconds, milliseconds,
		microseconds, output ready);
endinterface

// ----- sv/cycle_counter_timebase_unit.sv -----
// Cycle counter timebase: wrap extension to 64 bits and a seconds/ms/us split.
// Depends on ctb_pkg, ctb_sample_if and ctb_result_if.
//
//   channel  | kind            | payload
//   ---------+-----------------+-------------------------------------------------
//   sample   | valid/ready in  | cycle_count, reference_count
//   result   | valid/ready out | elapsed_cycles, total_cycles, seconds, ms, us
//   cfg      | write only      | counter clock in MHz (cfg_we, cfg_wdata)
//
// One beat runs from accept to result valid through 45 steps of the shared
// restoring divide stage for seconds, 10 for milliseconds, 10 for microseconds,
// and then the output state. The sample side is ready again in the cycle after
// the result is loaded, so no new sample is taken while a beat is in progress.
// Reset clears the wrap count, last sample and output valid, and sets 168 MHz.
// A stalled result holds in the output register; the next sample is taken meanwhile
// and its result waits in the output state until the output register is free.
module cycle_counter_timebase_unit #(
	parameter int RAW_WIDTH = ctb_pkg::RAW_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ctb_sample_if.sink                 sample,
	ctb_result_if.source               result,
	input  logic                       cfg_we,
	input  logic [ctb_pkg::FREQ_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_S,
		S_DIV_MS,
		S_DIV_US,
		S_OUT
	} state_t;

	state_t state_q;

	logic [ctb_pkg::FREQ_W-1:0]  freq_q;
	logic [31:0]                 wrap_q;
	logic [RAW_WIDTH-1:0]        last_q;

	logic [ctb_pkg::COUNT_W-1:0] div_q;
	logic [ctb_pkg::COUNT_W-1:0] rem_q;
	logic [ctb_pkg::SEC_W-1:0]   sh_q;
	logic [ctb_pkg::STEP_W-1:0]  cnt_q;

	logic [ctb_pkg::COUNT_W-1:0] elapsed_q;
	logic [ctb_pkg::TOTAL_W-1:0] total_q;
	logic [ctb_pkg::SEC_W-1:0]   secs_q;
	logic [ctb_pkg::SUB_W-1:0]   ms_q;
	logic [ctb_pkg::SUB_W-1:0]   us_q;

	logic [RAW_WIDTH-1:0]        now;
	logic [RAW_WIDTH-1:0]        ref_smp;
	logic [RAW_WIDTH-1:0]        elap_raw;
	logic [31:0]                 wrap_next;
	logic [ctb_pkg::TOTAL_W-1:0] total;
	logic [ctb_pkg::FREQ_W-1:0]  f_eff;
	logic [ctb_pkg::COUNT_W-1:0] per_s;
	logic [ctb_pkg::COUNT_W-1:0] per_ms;

	logic [ctb_pkg::COUNT_W:0]   shifted;
	logic [ctb_pkg::COUNT_W+1:0] diff;
	logic                        take;
	logic [ctb_pkg::COUNT_W-1:0] rem_next;
	logic [ctb_pkg::SEC_W-1:0]   sh_next;
	logic                        last_step;
	logic                        accept;
	logic                        out_free;

	assign now      = sample.cycle_count[RAW_WIDTH-1:0];
	assign ref_smp  = sample.reference_count[RAW_WIDTH-1:0];
	assign elap_raw = now - ref_smp;
	assign wrap_next = (now < last_q) ? wrap_q + 32'd1 : wrap_q;
	assign total    = (ctb_pkg::TOTAL_W'(wrap_next) << RAW_WIDTH) | ctb_pkg::TOTAL_W'(now);

	assign f_eff  = (freq_q == '0) ? ctb_pkg::FREQ_W'(1) : freq_q;
	assign per_s  = ctb_pkg::COUNT_W'(ctb_pkg::COUNT_W'(f_eff) * ctb_pkg::CYC_PER_S_PER_MHZ);
	assign per_ms = ctb_pkg::COUNT_W'(ctb_pkg::COUNT_W'(f_eff) * ctb_pkg::CYC_PER_MS_PER_MHZ);

	// shared restoring divide step, one quotient bit per cycle
	assign shifted  = {rem_q, sh_q[ctb_pkg::SEC_W-1]};
	assign diff     = {1'b0, shifted} - {2'b00, div_q};
	assign take     = ~diff[ctb_pkg::COUNT_W+1];
	assign rem_next = take ? diff[ctb_pkg::COUNT_W-1:0] : shifted[ctb_pkg::COUNT_W-1:0];
	assign sh_next  = {sh_q[ctb_pkg::SEC_W-2:0], take};
	assign last_step = (cnt_q == ctb_pkg::STEP_W'(1));

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid & sample.ready;
	assign out_free     = ~result.valid | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q       <= ctb_pkg::FREQ_RESET;
			wrap_q       <= '0;
			last_q       <= '0;
			state_q      <= S_IDLE;
			result.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				freq_q <= cfg_wdata;
			end
			if (result.valid && result.ready && state_q != S_OUT) begin
				result.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						wrap_q    <= wrap_next;
						last_q    <= now;
						total_q   <= total;
						elapsed_q <= ctb_pkg::COUNT_W'(elap_raw);
						rem_q     <= ctb_pkg::COUNT_W'(total[ctb_pkg::TOTAL_W-1:ctb_pkg::SEC_W]);
						sh_q      <= total[ctb_pkg::SEC_W-1:0];
						div_q     <= per_s;
						cnt_q     <= ctb_pkg::STEP_W'(ctb_pkg::SEC_W);
						state_q   <= S_DIV_S;
					end
				end
				S_DIV_S, S_DIV_MS, S_DIV_US: begin
					if (last_step) begin
						// quotients below 1024 start with the top bits already in the remainder
						rem_q <= ctb_pkg::COUNT_W'(rem_next[ctb_pkg::COUNT_W-1:ctb_pkg::SUB_W]);
						sh_q  <= {rem_next[ctb_pkg::SUB_W-1:0],
							(ctb_pkg::SEC_W - ctb_pkg::SUB_W)'(0)};
						cnt_q <= ctb_pkg::STEP_W'(ctb_pkg::SUB_W);
						if (state_q == S_DIV_S) begin
							secs_q  <= sh_next;
							div_q   <= per_ms;
							state_q <= S_DIV_MS;
						end else if (state_q == S_DIV_MS) begin
							ms_q    <= sh_next[ctb_pkg::SUB_W-1:0];
							div_q   <= ctb_pkg::COUNT_W'(f_eff);
							state_q <= S_DIV_US;
						end else begin
							us_q    <= sh_next[ctb_pkg::SUB_W-1:0];
							state_q <= S_OUT;
						end
					end else begin
						rem_q <= rem_next;
						sh_q  <= sh_next;
						cnt_q <= cnt_q - ctb_pkg::STEP_W'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						result.valid          <= 1'b1;
						result.elapsed_cycles <= elapsed_q;
						result.total_cycles   <= total_q;
						result.seconds        <= secs_q;
						result.milliseconds   <= ms_q;
						result.microseconds   <= us_q;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/ctb_checker.sv -----
// Port-level checks for the cycle counter timebase, attached by bind.
// Depends on ctb_pkg and the top level's port list.
module ctb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        sample_valid,
	input logic                        sample_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [ctb_pkg::TOTAL_W-1:0] result_total,
	input logic [ctb_pkg::SUB_W-1:0]   result_ms,
	input logic [ctb_pkg::SUB_W-1:0]   result_us
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_total))
		else $error("result beat dropped or changed while stalled");

	// the divider keeps the sample side busy after a beat is taken
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while divider busy");

	a_busy_long: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |-> ##60 !sample_ready)
		else $error("sample side ready before divide sequence done");

	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_ms < ctb_pkg::SUB_W'(1000)) && (result_us < ctb_pkg::SUB_W'(1000)))
		else $error("millisecond or microsecond field out of range");

endmodule

bind cycle_counter_timebase_unit ctb_checker u_ctb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_total (result.total_cycles),
	.result_ms    (result.milliseconds),
	.result_us    (result.microseconds)
);
